// ===== hw/rtl/lel_pkg.sv =====
// lel_pkg: shared types and constants for the local line editor
// no dependencies; imported by every lel_* module and the top level
package lel_pkg;

    typedef struct packed {
        logic line_editing;
        logic echo_enable;
        logic utf8_mode;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] cols;
    } t_emit;

    typedef struct packed {
        logic emit_valid;
        logic finish;
    } t_seq_ctl;

    typedef struct packed {
        logic ready;
    } t_out_ctl;

    localparam logic [1:0] KIND_TERM  = 2'd0;
    localparam logic [1:0] KIND_CHILD = 2'd1;
    localparam logic [1:0] KIND_ERASE = 2'd2;

    localparam logic [1:0] CFG_LINE_EDITING = 2'd0;
    localparam logic [1:0] CFG_ECHO_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_UTF8_MODE    = 2'd2;

    localparam logic [8:0] KEY_BS     = 9'h108;
    localparam logic [8:0] KEY_DEL    = 9'h17F;
    localparam logic [8:0] KEY_WORD   = 9'h017;
    localparam logic [8:0] KEY_REDRAW = 9'h012;
    localparam logic [8:0] KEY_QUOTE  = 9'h016;
    localparam logic [8:0] KEY_EOF    = 9'h004;
    localparam logic [8:0] KEY_ENTER  = 9'h10D;
    localparam logic [8:0] KEY_KILL   = 9'h015;
    localparam logic [8:0] KEY_INTR   = 9'h003;
    localparam logic [8:0] KEY_QUIT   = 9'h01C;
    localparam logic [8:0] KEY_SUSP   = 9'h01A;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CTRL_SHOW = 8'h40;

endpackage

// ===== hw/rtl/lel_glyph.sv =====
// lel_glyph: shared glyph unit, gives one echo character per sub step and the column width
// depends on lel_pkg
module lel_glyph (
    input  logic [7:0] i_byte,
    input  logic       i_utf8,
    input  logic [1:0] i_sub,
    output logic [7:0] o_char,
    output logic [1:0] o_last_sub,
    output logic [2:0] o_width
);
    import lel_pkg::*;

    logic plain_print;
    logic shown;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] v;
        v = {4'h0, n};
        hex_char = (n < 4'd10) ? (v + 8'h30) : (v + 8'h37);
    endfunction

    always_comb begin
        plain_print = (i_byte >= CH_SPACE) && (i_byte < CH_DEL);
        shown = plain_print || (!i_utf8 && i_byte >= 8'hA0) || (i_utf8 && i_byte[7]);
        o_char = i_byte;
        o_last_sub = 2'd0;
        if (!shown && !i_byte[7]) begin
            o_last_sub = 2'd1;
            if (i_sub == 2'd0) begin
                o_char = CH_CARET;
            end else if (i_byte == CH_DEL) begin
                o_char = CH_QMARK;
            end else begin
                o_char = i_byte + CTRL_SHOW;
            end
        end else if (!shown) begin
            o_last_sub = 2'd3;
            case (i_sub)
                2'd0:    o_char = CH_LT;
                2'd1:    o_char = hex_char(i_byte[7:4]);
                2'd2:    o_char = hex_char(i_byte[3:0]);
                default: o_char = CH_GT;
            endcase
        end
    end

    always_comb begin
        if (plain_print || (!i_utf8 && i_byte >= 8'hA0)) begin
            o_width = 3'd1;
        end else if (!i_byte[7]) begin
            o_width = 3'd2;
        end else if (i_utf8 && i_byte[6]) begin
            o_width = 3'd1;
        end else if (i_utf8) begin
            o_width = 3'd0;
        end else begin
            o_width = 3'd4;
        end
    end

endmodule

// ===== hw/rtl/lel_out.sv =====
// lel_out: one-item hold stage and output register, marks the final item of each key
// depends on lel_pkg
module lel_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lel_pkg::t_seq_ctl  i_seq_ctl,
    input  lel_pkg::t_emit     i_emit,
    input  logic               i_out_stall,
    output lel_pkg::t_out_ctl  o_out_ctl,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_data_byte,
    output logic [2:0]         o_erase_columns,
    output logic               o_last
);
    import lel_pkg::*;

    logic  r_hold_valid;
    t_emit r_hold;
    logic  r_out_valid;
    t_emit r_out;
    logic  r_last;
    logic  out_free;
    logic  ready;
    logic  move;

    assign out_free = !r_out_valid || !i_out_stall;
    assign ready = !r_hold_valid || out_free;
    assign move = r_hold_valid && out_free && (i_seq_ctl.emit_valid || i_seq_ctl.finish);
    assign o_out_ctl.ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (i_seq_ctl.emit_valid && ready) begin
                r_hold_valid <= 1'b1;
            end else if (i_seq_ctl.finish && ready) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out  <= r_hold;
            r_last <= i_seq_ctl.finish;
        end
        if (i_seq_ctl.emit_valid && ready) begin
            r_hold <= i_emit;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_data_byte     = r_out.data;
    assign o_erase_columns = r_out.cols;
    assign o_last          = r_last;

endmodule

// ===== hw/rtl/lel_seq.sv =====
// lel_seq: key decoder, line store and sequencer that walks the store through the glyph unit
// depends on lel_pkg and lel_glyph
module lel_seq #(
    parameter int LINE_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lel_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_key_byte,
    input  logic               i_is_special,
    input  logic               i_interactive,
    input  lel_pkg::t_out_ctl  i_out_ctl,
    output lel_pkg::t_seq_ctl  o_seq_ctl,
    output lel_pkg::t_emit     o_emit
);
    import lel_pkg::*;

    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int LEN_W = $clog2(LINE_DEPTH + 1);
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LINE_DEPTH);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_SEND   = 11'b000_0000_0010,
        S_ERASE  = 11'b000_0000_0100,
        S_PASS   = 11'b000_0000_1000,
        S_BS     = 11'b000_0001_0000,
        S_WORD   = 11'b000_0010_0000,
        S_HDR    = 11'b000_0100_0000,
        S_REDRAW = 11'b000_1000_0000,
        S_ECHO   = 11'b001_0000_0000,
        S_TAIL   = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        C_EDIT  = 2'd0,
        C_PASS  = 2'd1,
        C_EOF   = 2'd2,
        C_ENTER = 2'd3
    } t_cmd;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [LEN_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [1:0] r_sub, n_sub;
    logic r_quote, n_quote;
    logic r_first, n_first;
    logic r_empty, n_empty;
    logic [7:0] r_kb, n_kb;
    logic [7:0] r_prev, n_prev;
    logic [7:0] r_store [LINE_DEPTH];

    logic [LEN_W-1:0] len_m1;
    logic len_zero;
    logic send_end;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0] rd_byte;
    logic [7:0] glyph_in;
    logic [7:0] g_char;
    logic [1:0] g_last_sub;
    logic [2:0] g_width;
    logic wr_en;
    logic is_enter;
    logic do_store;
    logic go;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_start(input logic [7:0] c, input logic utf8);
        is_start = !utf8 || (c[7:6] != 2'b10);
    endfunction

    assign len_m1   = r_len - LEN_W'(1);
    assign len_zero = (r_len == '0);
    assign send_end = (LEN_W'(r_idx) == len_m1);
    assign rd_idx   = (r_state == S_ERASE || r_state == S_BS || r_state == S_WORD)
                      ? len_m1[IDX_W-1:0] : r_idx;
    assign rd_byte  = r_store[rd_idx];
    assign glyph_in = (r_state == S_ECHO) ? r_kb : rd_byte;
    assign is_enter = ({i_is_special, i_key_byte} == KEY_ENTER)
                      || (!i_is_special && !i_interactive && i_key_byte == CH_CR);

    lel_glyph u_glyph (
        .i_byte     (glyph_in),
        .i_utf8     (i_cfg.utf8_mode),
        .i_sub      (r_sub),
        .o_char     (g_char),
        .o_last_sub (g_last_sub),
        .o_width    (g_width)
    );

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_idx   = r_idx;
        n_sub   = r_sub;
        n_quote = r_quote;
        n_first = r_first;
        n_empty = r_empty;
        n_kb    = r_kb;
        n_prev  = r_prev;
        wr_en   = 1'b0;
        do_store = 1'b0;
        o_seq_ctl = '0;
        o_emit  = '0;
        go      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kb  = i_key_byte;
                    n_idx = '0;
                    n_sub = 2'd0;
                    n_cmd = C_EDIT;
                    n_state = S_FINISH;
                    if (!i_cfg.line_editing) begin
                        n_cmd = C_PASS;
                        n_state = len_zero ? S_PASS : S_SEND;
                    end else if (r_quote) begin
                        do_store = 1'b1;
                    end else if (is_enter) begin
                        n_cmd = C_ENTER;
                        n_empty = len_zero;
                        n_state = len_zero ? S_TAIL : S_SEND;
                    end else begin
                        unique case ({i_is_special, i_key_byte}) inside
                            KEY_BS, KEY_DEL: n_state = S_BS;
                            KEY_WORD: begin
                                n_state = S_WORD;
                                n_first = 1'b1;
                            end
                            KEY_REDRAW: n_state = i_cfg.echo_enable ? S_HDR : S_FINISH;
                            KEY_QUOTE:  n_quote = 1'b1;
                            KEY_EOF: begin
                                n_cmd = C_EOF;
                                n_state = len_zero ? S_FINISH : S_SEND;
                            end
                            KEY_KILL, KEY_INTR, KEY_QUIT, KEY_SUSP: n_state = S_ERASE;
                            default: do_store = 1'b1;
                        endcase
                    end
                    if (do_store) begin
                        n_quote = 1'b0;
                        if (r_len < DEPTH_L) begin
                            wr_en = 1'b1;
                            n_len = r_len + LEN_W'(1);
                            n_state = i_cfg.echo_enable ? S_ECHO : S_FINISH;
                        end
                    end
                end
            end
            S_SEND: begin
                o_seq_ctl.emit_valid = 1'b1;
                o_emit.kind = KIND_CHILD;
                o_emit.data = rd_byte;
                if (i_out_ctl.ready) begin
                    if (send_end) begin
                        n_idx = '0;
                        n_sub = 2'd0;
                        case (r_cmd)
                            C_PASS: n_state = S_ERASE;
                            C_EOF: begin
                                n_len = '0;
                                n_state = S_FINISH;
                            end
                            C_ENTER: begin
                                n_len = '0;
                                n_state = S_TAIL;
                            end
                            default: n_state = S_FINISH;
                        endcase
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_ERASE: begin
                if (len_zero) begin
                    n_sub = 2'd0;
                    n_state = (r_cmd == C_PASS) ? S_PASS : S_FINISH;
                end else begin
                    o_seq_ctl.emit_valid = ((r_cmd == C_PASS) || i_cfg.echo_enable)
                                           && (g_width != 3'd0);
                    o_emit.kind = KIND_ERASE;
                    o_emit.cols = g_width;
                    go = !o_seq_ctl.emit_valid || i_out_ctl.ready;
                    if (go) begin
                        n_len = len_m1;
                    end
                end
            end
            S_PASS: begin
                o_emit.data = r_kb;
                if (r_sub == 2'd0) begin
                    o_seq_ctl.emit_valid = i_cfg.echo_enable;
                    o_emit.kind = KIND_TERM;
                    go = !o_seq_ctl.emit_valid || i_out_ctl.ready;
                    if (go) begin
                        n_sub = 2'd1;
                    end
                end else begin
                    o_seq_ctl.emit_valid = 1'b1;
                    o_emit.kind = KIND_CHILD;
                    if (i_out_ctl.ready) begin
                        n_sub = 2'd0;
                        n_state = S_FINISH;
                    end
                end
            end
            S_BS: begin
                if (len_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_seq_ctl.emit_valid = i_cfg.echo_enable && (g_width != 3'd0);
                    o_emit.kind = KIND_ERASE;
                    o_emit.cols = g_width;
                    go = !o_seq_ctl.emit_valid || i_out_ctl.ready;
                    if (go) begin
                        n_len = len_m1;
                        if (is_start(rd_byte, i_cfg.utf8_mode)) begin
                            n_state = S_FINISH;
                        end
                    end
                end
            end
            S_WORD: begin
                if (len_zero) begin
                    n_state = S_FINISH;
                end else if (!r_first && is_space(rd_byte) && !is_space(r_prev)) begin
                    n_state = S_FINISH;
                end else begin
                    o_seq_ctl.emit_valid = i_cfg.echo_enable && (g_width != 3'd0);
                    o_emit.kind = KIND_ERASE;
                    o_emit.cols = g_width;
                    go = !o_seq_ctl.emit_valid || i_out_ctl.ready;
                    if (go) begin
                        n_len = len_m1;
                        n_prev = rd_byte;
                        n_first = 1'b0;
                    end
                end
            end
            S_HDR: begin
                o_seq_ctl.emit_valid = 1'b1;
                o_emit.kind = KIND_TERM;
                case (r_sub)
                    2'd0:    o_emit.data = CH_CARET;
                    2'd1:    o_emit.data = CH_R;
                    2'd2:    o_emit.data = CH_CR;
                    default: o_emit.data = CH_LF;
                endcase
                if (i_out_ctl.ready) begin
                    if (r_sub == 2'd3) begin
                        n_sub = 2'd0;
                        n_idx = '0;
                        n_state = len_zero ? S_FINISH : S_REDRAW;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            S_REDRAW: begin
                o_seq_ctl.emit_valid = 1'b1;
                o_emit.kind = KIND_TERM;
                o_emit.data = g_char;
                if (i_out_ctl.ready) begin
                    if (r_sub == g_last_sub) begin
                        n_sub = 2'd0;
                        if (send_end) begin
                            n_idx = '0;
                            n_state = S_FINISH;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            S_ECHO: begin
                o_seq_ctl.emit_valid = 1'b1;
                o_emit.kind = KIND_TERM;
                o_emit.data = g_char;
                if (i_out_ctl.ready) begin
                    if (r_sub == g_last_sub) begin
                        n_sub = 2'd0;
                        n_state = S_FINISH;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            S_TAIL: begin
                o_emit.data = CH_CR;
                if (r_sub == 2'd0) begin
                    o_seq_ctl.emit_valid = r_empty;
                    o_emit.kind = KIND_CHILD;
                end else begin
                    o_seq_ctl.emit_valid = i_cfg.echo_enable;
                    o_emit.kind = KIND_TERM;
                    if (r_sub != 2'd1) begin
                        o_emit.data = CH_LF;
                    end
                end
                go = !o_seq_ctl.emit_valid || i_out_ctl.ready;
                if (go) begin
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        n_len = '0;
                        n_state = S_FINISH;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end
            end
            S_FINISH: begin
                o_seq_ctl.finish = 1'b1;
                if (i_out_ctl.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= C_EDIT;
            r_len   <= '0;
            r_idx   <= '0;
            r_sub   <= 2'd0;
            r_quote <= 1'b0;
            r_first <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
            r_quote <= n_quote;
            r_first <= n_first;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kb   <= n_kb;
        r_prev <= n_prev;
        if (wr_en) begin
            r_store[r_len[IDX_W-1:0]] <= i_key_byte;
        end
    end

endmodule

// ===== hw/rtl/local_line_editor.sv =====
// local_line_editor: top level of the local line editor, holds the configuration registers
// depends on lel_pkg, lel_seq and lel_out
//
// use: one key item enters on i_in_valid while o_in_stall is low (key byte, special flag,
// interactive flag). the block then stalls its input while a sequencer walks the line
// store, one step per cycle while the output is ready, and produces zero or more result
// items on the output channel (kind, data byte, erase columns, last). o_last marks the
// final item of a key; a key that causes nothing produces no item.
// timing: the sequencer works through a key in steps. a step sends one result item,
// removes a byte with no erase item, skips an echo step that is off or makes the closing
// check of an erase loop. a redraw of a full line of hex glyphs is the longest sequence.
// each result item is registered in the hold stage and then in the output register.
// a receiver stall on i_out_stall holds the output register; the sequencer puts one
// more item into the hold stage and then waits, so nothing is lost.
// configuration: writes on the cfg channel are always taken and should be made while
// the block is idle. index 0 line editing, 1 echo, 2 utf-8; bit 0 of the data is used.
// reset: clears the line, the quote-next flag and both channels; line editing and echo
// come up on, utf-8 off. no clearing pass is needed.
module local_line_editor #(
    parameter int LINE_DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_key_byte,
    input  logic       i_is_special,
    input  logic       i_interactive,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_erase_columns,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic       i_cfg_data
);
    import lel_pkg::*;

    t_cfg     r_cfg;
    t_seq_ctl seq_ctl;
    t_out_ctl out_ctl;
    t_emit    emit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_editing <= 1'b1;
            r_cfg.echo_enable  <= 1'b1;
            r_cfg.utf8_mode    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINE_EDITING: r_cfg.line_editing <= i_cfg_data;
                CFG_ECHO_ENABLE:  r_cfg.echo_enable  <= i_cfg_data;
                CFG_UTF8_MODE:    r_cfg.utf8_mode    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lel_seq #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_key_byte    (i_key_byte),
        .i_is_special  (i_is_special),
        .i_interactive (i_interactive),
        .i_out_ctl     (out_ctl),
        .o_seq_ctl     (seq_ctl),
        .o_emit        (emit)
    );

    lel_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_seq_ctl       (seq_ctl),
        .i_emit          (emit),
        .i_out_stall     (i_out_stall),
        .o_out_ctl       (out_ctl),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_erase_columns (o_erase_columns),
        .o_last          (o_last)
    );

endmodule

// ===== hw/rtl/lel_checker.sv =====
// lel_checker: port-level checks on the local line editor, bound to the top level
// depends on lel_pkg and local_line_editor
module lel_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_data_byte,
    input logic [2:0] o_erase_columns,
    input logic       o_last
);
    import lel_pkg::*;

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an item was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable({o_kind, o_data_byte, o_erase_columns, o_last}))
        else $error("stalled result item changed");

    a_erase_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_ERASE |-> o_data_byte == 8'd0
            && o_erase_columns != 3'd0 && o_erase_columns <= 3'd4)
        else $error("erase item with bad columns or data");

    a_byte_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != KIND_ERASE |-> o_erase_columns == 3'd0
            && (o_kind == KIND_TERM || o_kind == KIND_CHILD))
        else $error("byte item with bad kind or columns");

endmodule

bind local_line_editor lel_checker u_lel_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_kind          (o_kind),
    .o_data_byte     (o_data_byte),
    .o_erase_columns (o_erase_columns),
    .o_last          (o_last)
);
